/* sv/rppc_pkg.sv */
// Package for the pivot rotation core: beat types, fixed-point widths and
// the constant sine/cosine table built at elaboration. No dependencies.

package rppc_pkg;

  // Field widths
  localparam int COORD_W         = 16;
  localparam int ANGLE_W         = 9;
  localparam int CFG_IDX_W       = 2;
  localparam int ANGLE_STEPS     = 360;
  localparam int COORD_FRAC_BITS = 4;
  localparam int TRIG_FRAC_BITS  = 15;

  // Datapath widths
  localparam int TRIG_W  = TRIG_FRAC_BITS + 2;       // holds -1.0 .. +1.0
  localparam int DIFF_W  = COORD_W + 1;              // point minus pivot
  localparam int PROD_W  = DIFF_W + TRIG_W;          // one product
  localparam int SUM_W   = PROD_W + 1;               // sum of two products
  localparam int ROT_W   = SUM_W - TRIG_FRAC_BITS;   // rounded rotated offset
  localparam int TOTAL_W = ROT_W + 1;                // offset plus pivot
  localparam int K_W     = $clog2(ANGLE_STEPS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y = CFG_IDX_W'(1);

  // Pivot reset: 250.0 in Q12.4, clamped to the coordinate range
  localparam int PIVOT_RESET_INT = (250 << COORD_FRAC_BITS) > 32767 ?
                                   32767 : (250 << COORD_FRAC_BITS);
  localparam logic signed [COORD_W-1:0] PIVOT_RESET = COORD_W'(PIVOT_RESET_INT);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Input and result beats
  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic        [ANGLE_W-1:0] angle_deg;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      clipped;
  } out_beat_t;

  // Table type: one entry per angle step
  typedef logic [ANGLE_STEPS-1:0][TRIG_W-1:0] trig_tab_t;

  // Constants of the integer Taylor evaluation (Q30)
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = PI_Q30 / 2;
  localparam longint          ONE_Q30     = 64'sd1073741824;
  localparam longint unsigned SIN_DIV [9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};
  localparam longint unsigned COS_DIV [9] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};

  // Clamp to [0, 1.0] and round Q30 down to the table precision
  function automatic longint round_q30(input longint s);
    longint v;
    v = s;
    if (v < 0) v = 0;
    if (v > ONE_Q30) v = ONE_Q30;
    return (v + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
  endfunction

  // Build the sine (want_cos = 0) or cosine (want_cos = 1) table
  function automatic trig_tab_t build_trig_tab(input bit want_cos);
    trig_tab_t       tab;
    longint unsigned a, q, r, r2, st, ct;
    longint          ssum, csum, s, c, val;
    tab = '0;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      a    = (2 * PI_Q30 * longint'(k)) / ANGLE_STEPS;
      q    = a / HALF_PI_Q30;
      r    = a - q * HALF_PI_Q30;
      r2   = (r * r) >> 30;
      ssum = longint'(r);
      csum = ONE_Q30;
      st   = r;
      ct   = ONE_Q30;
      for (int i = 0; i < 9; i++) begin
        st = ((st * r2) >> 30) / SIN_DIV[i];
        ct = ((ct * r2) >> 30) / COS_DIV[i];
        // even index here is an odd term number: subtract
        if ((i % 2) == 0) begin
          ssum = ssum - longint'(st);
          csum = csum - longint'(ct);
        end else begin
          ssum = ssum + longint'(st);
          csum = csum + longint'(ct);
        end
      end
      s = round_q30(ssum);
      c = round_q30(csum);
      case (q % 4)
        0:       val = want_cos ? c  : s;
        1:       val = want_cos ? -s : c;
        2:       val = want_cos ? -c : -s;
        default: val = want_cos ? s  : -c;
      endcase
      tab[k] = val[TRIG_W-1:0];
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig_tab(1'b0);
  localparam trig_tab_t COS_TAB = build_trig_tab(1'b1);

endpackage

/* sv/rotate_point_about_pivot_core.sv */
// Top level of the pivot rotation core: five-stage pipeline with per-stage
// valid bits. Depends on rppc_pkg for beat types, widths and trig tables.

// Rotates each point counterclockwise about the pivot held in pivot_x and
// pivot_y (Q12.4, reset 250.0) by angle_deg whole degrees; angles 360..511
// wrap. Results are rounded half up and saturated to the 16-bit range, with
// clipped raised when either coordinate hit a bound. One point per cycle is
// accepted unless out_ready back-pressure stalls the pipe; the five register stages
// are offset and angle wrap, sine/cosine table read, the four 17x17
// multiplies, sum and round, then pivot add and saturate. Each stage holds
// only while the one after it is full and held, so bubbles are squeezed out
// under back-pressure. Write the pivot only while no point is in flight.

module rotate_point_about_pivot_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rppc_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rppc_pkg::out_beat_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [rppc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rppc_pkg::COORD_W-1:0]        cfg_wdata
);

  // Pivot registers
  logic signed [rppc_pkg::COORD_W-1:0] pivot_x_r, pivot_y_r;

  // Stage valid bits and load enables
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic s1_en, s2_en, s3_en, s4_en, out_en;

  // Stage 1: offsets and wrapped angle
  logic signed [rppc_pkg::DIFF_W-1:0] s1_dx_r, s1_dy_r, s1_dx_nxt, s1_dy_nxt;
  logic        [rppc_pkg::K_W-1:0]    s1_k_r, s1_k_nxt;

  // Stage 2: offsets and trig values
  logic signed [rppc_pkg::DIFF_W-1:0] s2_dx_r, s2_dy_r;
  logic signed [rppc_pkg::TRIG_W-1:0] s2_sin_r, s2_cos_r;

  // Stage 3: products
  logic signed [rppc_pkg::PROD_W-1:0] s3_xc_r, s3_ys_r, s3_xs_r, s3_yc_r;
  logic signed [rppc_pkg::PROD_W-1:0] s3_xc_nxt, s3_ys_nxt, s3_xs_nxt, s3_yc_nxt;

  // Stage 4: rounded rotated offsets
  logic signed [rppc_pkg::SUM_W-1:0]  sum_x, sum_y;
  logic signed [rppc_pkg::ROT_W-1:0]  s4_rx_r, s4_ry_r;

  // Output stage
  logic signed [rppc_pkg::TOTAL_W-1:0] tot_x, tot_y;
  logic signed [rppc_pkg::COORD_W-1:0] sat_x, sat_y;
  logic                                clip_x, clip_y;
  rppc_pkg::out_beat_t                 out_data_r, out_data_nxt;

  // Load a stage when it is empty or its contents move on
  assign out_en   = !out_valid_r || out_ready;
  assign s4_en    = !s4_valid_r  || out_en;
  assign s3_en    = !s3_valid_r  || s4_en;
  assign s2_en    = !s2_valid_r  || s3_en;
  assign s1_en    = !s1_valid_r  || s2_en;
  assign in_ready = s1_en;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_x_r <= rppc_pkg::PIVOT_RESET;
      pivot_y_r <= rppc_pkg::PIVOT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rppc_pkg::REG_PIVOT_X: pivot_x_r <= cfg_wdata;
        rppc_pkg::REG_PIVOT_Y: pivot_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_r  <= in_valid;
      if (s2_en)  s2_valid_r  <= s1_valid_r;
      if (s3_en)  s3_valid_r  <= s2_valid_r;
      if (s4_en)  s4_valid_r  <= s3_valid_r;
      if (out_en) out_valid_r <= s4_valid_r;
    end
  end

  // Stage 1: subtract pivot, wrap angle into the table range
  always_comb begin
    s1_dx_nxt = rppc_pkg::DIFF_W'(in_data.in_x) - rppc_pkg::DIFF_W'(pivot_x_r);
    s1_dy_nxt = rppc_pkg::DIFF_W'(in_data.in_y) - rppc_pkg::DIFF_W'(pivot_y_r);
    if (in_data.angle_deg >= rppc_pkg::ANGLE_W'(rppc_pkg::ANGLE_STEPS)) begin
      s1_k_nxt = rppc_pkg::K_W'(in_data.angle_deg
                 - rppc_pkg::ANGLE_W'(rppc_pkg::ANGLE_STEPS));
    end else begin
      s1_k_nxt = rppc_pkg::K_W'(in_data.angle_deg);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_dx_r <= s1_dx_nxt;
      s1_dy_r <= s1_dy_nxt;
      s1_k_r  <= s1_k_nxt;
    end
  end

  // Stage 2: read sine and cosine
  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_dx_r  <= s1_dx_r;
      s2_dy_r  <= s1_dy_r;
      s2_sin_r <= rppc_pkg::SIN_TAB[s1_k_r];
      s2_cos_r <= rppc_pkg::COS_TAB[s1_k_r];
    end
  end

  // Stage 3: four products
  always_comb begin
    s3_xc_nxt = rppc_pkg::PROD_W'(s2_dx_r) * rppc_pkg::PROD_W'(s2_cos_r);
    s3_ys_nxt = rppc_pkg::PROD_W'(s2_dy_r) * rppc_pkg::PROD_W'(s2_sin_r);
    s3_xs_nxt = rppc_pkg::PROD_W'(s2_dx_r) * rppc_pkg::PROD_W'(s2_sin_r);
    s3_yc_nxt = rppc_pkg::PROD_W'(s2_dy_r) * rppc_pkg::PROD_W'(s2_cos_r);
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_xc_r <= s3_xc_nxt;
      s3_ys_r <= s3_ys_nxt;
      s3_xs_r <= s3_xs_nxt;
      s3_yc_r <= s3_yc_nxt;
    end
  end

  // Stage 4: combine, add half an LSB, floor-shift down to Q16.4
  always_comb begin
    sum_x = rppc_pkg::SUM_W'(s3_xc_r) - rppc_pkg::SUM_W'(s3_ys_r)
          + (rppc_pkg::SUM_W'(1) <<< (rppc_pkg::TRIG_FRAC_BITS - 1));
    sum_y = rppc_pkg::SUM_W'(s3_xs_r) + rppc_pkg::SUM_W'(s3_yc_r)
          + (rppc_pkg::SUM_W'(1) <<< (rppc_pkg::TRIG_FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_rx_r <= sum_x[rppc_pkg::SUM_W-1:rppc_pkg::TRIG_FRAC_BITS];
      s4_ry_r <= sum_y[rppc_pkg::SUM_W-1:rppc_pkg::TRIG_FRAC_BITS];
    end
  end

  // Output stage: add pivot back and saturate
  always_comb begin
    tot_x = rppc_pkg::TOTAL_W'(s4_rx_r) + rppc_pkg::TOTAL_W'(pivot_x_r);
    tot_y = rppc_pkg::TOTAL_W'(s4_ry_r) + rppc_pkg::TOTAL_W'(pivot_y_r);
    clip_x = 1'b0;
    clip_y = 1'b0;
    if (tot_x > rppc_pkg::TOTAL_W'(rppc_pkg::COORD_MAX)) begin
      sat_x  = rppc_pkg::COORD_MAX;
      clip_x = 1'b1;
    end else if (tot_x < rppc_pkg::TOTAL_W'(rppc_pkg::COORD_MIN)) begin
      sat_x  = rppc_pkg::COORD_MIN;
      clip_x = 1'b1;
    end else begin
      sat_x = tot_x[rppc_pkg::COORD_W-1:0];
    end
    if (tot_y > rppc_pkg::TOTAL_W'(rppc_pkg::COORD_MAX)) begin
      sat_y  = rppc_pkg::COORD_MAX;
      clip_y = 1'b1;
    end else if (tot_y < rppc_pkg::TOTAL_W'(rppc_pkg::COORD_MIN)) begin
      sat_y  = rppc_pkg::COORD_MIN;
      clip_y = 1'b1;
    end else begin
      sat_y = tot_y[rppc_pkg::COORD_W-1:0];
    end
    out_data_nxt.out_x   = sat_x;
    out_data_nxt.out_y   = sat_y;
    out_data_nxt.clipped = clip_x | clip_y;
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* dv/rotate_point_about_pivot_core_test.sv */
// Self-checking testbench for rotate_point_about_pivot_core: rotated points are predicted
// from a locally built sine/cosine table and compared beat by beat.
// Depends on rppc_pkg for beat types, widths and register indexes.
`timescale 1ns / 100ps

typedef longint unsigned u64_t;

// Holds the pivot registers, the trig table and the rotated points still owed by the core
class rotation_ledger;
  localparam int     STEPS     = rppc_pkg::ANGLE_STEPS;
  localparam int     TF        = rppc_pkg::TRIG_FRAC_BITS;
  localparam u64_t   PI_FX30   = 64'd3373259426;
  localparam longint ONE_FX30  = 64'sd1073741824;
  localparam longint COORD_HI  = 32767;
  localparam longint COORD_LO  = -32768;

  int     sin_q [STEPS];
  int     cos_q [STEPS];
  longint pivot_x;
  longint pivot_y;
  rppc_pkg::out_beat_t rotated_due [$];
  int     errors;
  int     checked;
  int     clipped_seen;

  function new();
    pivot_x      = 250 << rppc_pkg::COORD_FRAC_BITS;
    pivot_y      = 250 << rppc_pkg::COORD_FRAC_BITS;
    errors       = 0;
    checked      = 0;
    clipped_seen = 0;
    build_trig();
  endfunction

  // Clamp a Q30 value to [0, 1.0] and round it to the table precision
  function int q30_to_trig(longint v);
    if (v < 0) v = 0;
    if (v > ONE_FX30) v = ONE_FX30;
    return int'((v + (longint'(1) << (29 - TF))) >>> (30 - TF));
  endfunction

  // Evaluate the first quadrant by integer Taylor series, then fold by quadrant
  function void build_trig();
    u64_t   half_pi, a, q, r, r2, st, ct;
    longint ssum, csum;
    int     s, c;
    half_pi = PI_FX30 / 2;
    for (int k = 0; k < STEPS; k++) begin
      a    = (2 * PI_FX30 * u64_t'(k)) / u64_t'(STEPS);
      q    = a / half_pi;
      r    = a - q * half_pi;
      r2   = (r * r) >> 30;
      ssum = longint'(r);
      csum = ONE_FX30;
      st   = r;
      ct   = u64_t'(ONE_FX30);
      for (int i = 1; i <= 9; i++) begin
        st = ((st * r2) >> 30) / u64_t'((2 * i) * (2 * i + 1));
        ct = ((ct * r2) >> 30) / u64_t'((2 * i - 1) * (2 * i));
        if ((i % 2) == 1) begin
          ssum = ssum - longint'(st);
          csum = csum - longint'(ct);
        end else begin
          ssum = ssum + longint'(st);
          csum = csum + longint'(ct);
        end
      end
      s = q30_to_trig(ssum);
      c = q30_to_trig(csum);
      case (q % 4)
        0: begin
          sin_q[k] = s;
          cos_q[k] = c;
        end
        1: begin
          sin_q[k] = c;
          cos_q[k] = -s;
        end
        2: begin
          sin_q[k] = -s;
          cos_q[k] = -c;
        end
        default: begin
          sin_q[k] = -c;
          cos_q[k] = s;
        end
      endcase
    end
  endfunction

  // Update a pivot; spare indexes change nothing
  function void write_reg(logic [rppc_pkg::CFG_IDX_W-1:0] idx,
                          logic [rppc_pkg::COORD_W-1:0] val);
    case (idx)
      rppc_pkg::REG_PIVOT_X: pivot_x = longint'($signed(val));
      rppc_pkg::REG_PIVOT_Y: pivot_y = longint'($signed(val));
      default: ;
    endcase
  endfunction

  // Saturate to the coordinate range, raising clip on a hit
  function longint clamp_coord(longint v, inout bit clip);
    if (v > COORD_HI) begin
      clip = 1'b1;
      return COORD_HI;
    end
    if (v < COORD_LO) begin
      clip = 1'b1;
      return COORD_LO;
    end
    return v;
  endfunction

  function rppc_pkg::out_beat_t rotate_about_pivot(rppc_pkg::in_beat_t b);
    rppc_pkg::out_beat_t res;
    longint dx, dy, sn, cs, rx, ry, ox, oy;
    int     k;
    bit     clip;
    clip = 1'b0;
    dx   = longint'($signed(b.in_x)) - pivot_x;
    dy   = longint'($signed(b.in_y)) - pivot_y;
    k    = int'(b.angle_deg) % STEPS;
    sn   = sin_q[k];
    cs   = cos_q[k];
    // round half up: add half an LSB, then floor
    rx   = (dx * cs - dy * sn + (longint'(1) << (TF - 1))) >>> TF;
    ry   = (dx * sn + dy * cs + (longint'(1) << (TF - 1))) >>> TF;
    ox   = clamp_coord(rx + pivot_x, clip);
    oy   = clamp_coord(ry + pivot_y, clip);
    res.out_x   = ox[15:0];
    res.out_y   = oy[15:0];
    res.clipped = clip;
    return res;
  endfunction

  function void note_point(rppc_pkg::in_beat_t b);
    rotated_due.push_back(rotate_about_pivot(b));
  endfunction

  function void check_result(rppc_pkg::out_beat_t got);
    rppc_pkg::out_beat_t want;
    if (rotated_due.size() == 0) begin
      $error("result beat with nothing outstanding: out_x=%0d out_y=%0d clipped=%0d",
             $signed(got.out_x), $signed(got.out_y), got.clipped);
      errors++;
      return;
    end
    want = rotated_due.pop_front();
    checked++;
    if (want.clipped) clipped_seen++;
    if (got.out_x !== want.out_x) begin
      $error("out_x mismatch: expected %0d, actual %0d", $signed(want.out_x), $signed(got.out_x));
      errors++;
    end
    if (got.out_y !== want.out_y) begin
      $error("out_y mismatch: expected %0d, actual %0d", $signed(want.out_y), $signed(got.out_y));
      errors++;
    end
    if (got.clipped !== want.clipped) begin
      $error("clipped mismatch: expected %0d, actual %0d", want.clipped, got.clipped);
      errors++;
    end
  endfunction
endclass

module rotate_point_about_pivot_core_test;

  localparam logic [rppc_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = rppc_pkg::CFG_IDX_W'(2);
  localparam logic [rppc_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = rppc_pkg::CFG_IDX_W'(3);
  localparam int PHASES          = 8;
  localparam int POINTS_PER_PHASE = 135;
  localparam int DRAIN_CYCLES    = 12;   // pipeline is five stages deep
  localparam logic [rppc_pkg::COORD_W-1:0] PIVOT_XS [6] = '{16'd4000, 16'd0, 16'h7fff,
                                                             16'h8000, 16'h7fff, 16'h8000};
  localparam logic [rppc_pkg::COORD_W-1:0] PIVOT_YS [6] = '{16'd4000, 16'd0, 16'h7fff,
                                                             16'h8000, 16'h8000, 16'h7fff};

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  rppc_pkg::in_beat_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  rppc_pkg::out_beat_t            out_data;
  logic                           cfg_wr_en;
  logic [rppc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rppc_pkg::COORD_W-1:0]   cfg_wdata;

  rotation_ledger ledger;
  bit             quiet;
  bit             tx_lively;
  bit             rx_lively;
  int             writes_done;

  rotate_point_about_pivot_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Give up well past the slowest legal run
  initial begin
    #1_000_000;
    $display("rotate_point_about_pivot_core_test: FAIL");
    $finish;
  end

  // Result side: random stall bursts, calm stretches, none at the end
  initial begin
    out_ready = 1'b0;
    rx_lively = 1'b1;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) rx_lively = !rx_lively;
      if (!quiet && rx_lively && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_result(out_data);
  end

  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 49) == 0) tx_lively = !tx_lively;
    if (tx_lively && $urandom_range(0, 4) == 0) return $urandom_range(1, 13);
    return 0;
  endfunction

  function automatic rppc_pkg::in_beat_t make_point(int x, int y, int a);
    rppc_pkg::in_beat_t b;
    b.in_x      = 16'(x);
    b.in_y      = 16'(y);
    b.angle_deg = 9'(a);
    return b;
  endfunction

  // Mix of full-range, near-pivot, edge and small coordinates
  function automatic logic [rppc_pkg::COORD_W-1:0] pick_coord(longint center);
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2, 3: return 16'(center + longint'($urandom_range(0, 4095)) - 2048);
      4: begin
        case ($urandom_range(0, 4))
          0:       return 16'h7fff;
          1:       return 16'h8000;
          2:       return 16'h0000;
          3:       return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      default: return 16'(longint'($urandom_range(0, 255)) - 128);
    endcase
  endfunction

  function automatic rppc_pkg::in_beat_t random_point();
    rppc_pkg::in_beat_t b;
    b.in_x = pick_coord(ledger.pivot_x);
    b.in_y = pick_coord(ledger.pivot_y);
    // now and then an angle past 359 to exercise the wrap
    if ($urandom_range(0, 7) == 0) begin
      b.angle_deg = rppc_pkg::ANGLE_W'($urandom_range(360, 511));
    end else begin
      b.angle_deg = rppc_pkg::ANGLE_W'($urandom_range(0, 359));
    end
    return b;
  endfunction

  // Drive one input beat after an optional gap; hold it until accepted
  task automatic send_beat(rppc_pkg::in_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    ledger.note_point(b);
  endtask

  task automatic cfg_beat(logic [rppc_pkg::CFG_IDX_W-1:0] idx,
                          logic [rppc_pkg::COORD_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    ledger.write_reg(idx, val);
    writes_done++;
  endtask

  // Write both pivots with spare-index writes in between; those must be ignored
  task automatic set_pivots(logic [rppc_pkg::COORD_W-1:0] px,
                            logic [rppc_pkg::COORD_W-1:0] py);
    cfg_beat(rppc_pkg::REG_PIVOT_X, px);
    cfg_beat(REG_SPARE_2, 16'($urandom));
    cfg_beat(rppc_pkg::REG_PIVOT_Y, py);
    cfg_beat(REG_SPARE_3, 16'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // Hold off the sender until every rotated point is back and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (ledger.rotated_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [rppc_pkg::COORD_W-1:0] px, py;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    quiet       = 1'b0;
    tx_lively   = 1'b1;
    writes_done = 0;
    ledger      = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points at the reset pivot: pivot itself, quarter turns, edges, wrap
    send_beat(make_point(4000, 4000, 0));
    send_beat(make_point(4000, 4000, 123));
    send_beat(make_point(32767, 32767, 0));
    send_beat(make_point(32767, 32767, 90));
    send_beat(make_point(32767, 32767, 45));
    send_beat(make_point(-32768, -32768, 180));
    send_beat(make_point(-32768, -32768, 0));
    send_beat(make_point(-32768, -32768, 45));
    send_beat(make_point(-32768, 32767, 270));
    send_beat(make_point(32767, -32768, 359));
    send_beat(make_point(32767, -32768, 135));
    send_beat(make_point(0, 0, 90));
    send_beat(make_point(-1, -1, 180));
    send_beat(make_point(100, -100, 360));
    send_beat(make_point(100, -100, 511));
    send_beat(make_point(4016, 4000, 1));
    send_beat(make_point(4001, 3999, 30));
    send_beat(make_point(0, 32767, 225));
    send_beat(make_point(12345, -23456, 300));
    send_beat(make_point(4000, -32768, 90));
    send_beat(make_point(4000, 4001, 270));
    wait_idle();

    // Random phases, each under its own pivot setting; the last one runs without input gaps or result stalls
    for (int p = 0; p < PHASES; p++) begin
      if (p < 6) begin
        px = PIVOT_XS[p];
        py = PIVOT_YS[p];
      end else begin
        px = 16'($urandom);
        py = 16'($urandom);
      end
      set_pivots(px, py);
      if (p == PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < POINTS_PER_PHASE; n++) send_beat(random_point());
      wait_idle();
    end

    if (ledger.rotated_due.size() != 0) begin
      $error("%0d rotated points never came back", ledger.rotated_due.size());
      ledger.errors++;
    end
    $display("Checked %0d rotated points (%0d saturated) over %0d pivot settings,",
             ledger.checked, ledger.clipped_seen, PHASES + 1);
    $display("with %0d register writes including spare indexes and wrapped angles.",
             writes_done);
    if (ledger.errors == 0) begin
      $display("rotate_point_about_pivot_core_test: PASS");
    end else begin
      $display("rotate_point_about_pivot_core_test: FAIL");
    end
    $finish;
  end
endmodule
